@@ rtl/wto_pkg.sv @@
// wto_pkg: constants, types and elaboration-time functions of the wavetable oscillator.
// Holds the sine quarter-wave ROM generator used by wto_sine_rom.
// No dependencies.
package wto_pkg;

	localparam int TABLE_SIZE      = 2048;
	localparam int PHASE_FRAC_BITS = 21;
	localparam int SAMPLE_BITS     = 16;
	localparam int ADDR_BITS       = $clog2(TABLE_SIZE);
	localparam int PHASE_BITS      = ADDR_BITS + PHASE_FRAC_BITS;
	localparam int STEP_BITS       = 32;
	localparam int FRAC_BITS       = 16;
	localparam int QTR_SIZE        = TABLE_SIZE / 4;
	localparam int QADDR_BITS      = $clog2(QTR_SIZE + 1);
	localparam int MAG_BITS        = SAMPLE_BITS - 1;
	localparam int AMP             = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam int SHAPE_BITS      = 2;
	localparam int CFG_BITS        = 32;
	localparam int CFG_IDX_BITS    = 1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SHAPE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP = 1'd1;

	// waveform codes
	localparam logic [SHAPE_BITS-1:0] SHAPE_SINE   = 2'd0;
	localparam logic [SHAPE_BITS-1:0] SHAPE_SAW    = 2'd1;
	localparam logic [SHAPE_BITS-1:0] SHAPE_SQUARE = 2'd2;

	localparam logic [63:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] ONE_Q62     = 64'd1 << 62;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [MAG_BITS-1:0]           mag_t;
	typedef logic [ADDR_BITS-1:0]          addr_t;
	typedef logic [QADDR_BITS-1:0]         qaddr_t;
	typedef mag_t                          sine_rom_t [QTR_SIZE+1];

	typedef struct packed {
		addr_t                idx0;
		addr_t                idx1;
		logic [FRAC_BITS-1:0] frac;
	} phase_pos_t;

	// (a*b) >> 62, Q2.62 product
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// |A*sin(pi/2 * j/QTR_SIZE)| rounded, Taylor series in Q62
	function automatic mag_t sine_mag(input int unsigned j);
		logic [63:0] n, q, whole, rem, hi, r2, f, x, x2, term, sum, t;
		n     = 64'(TABLE_SIZE);
		q     = 64'(j) * 64'd4;
		whole = q / TABLE_SIZE;
		rem   = q % TABLE_SIZE;
		hi    = (rem << 40) / TABLE_SIZE;
		r2    = (rem << 40) % TABLE_SIZE;
		f     = (whole << 62) + (hi << 22) + ((r2 << 22) / TABLE_SIZE);
		x     = mul_q62(f, PI_HALF_Q62);
		x2    = mul_q62(x, x);
		term  = x;
		sum   = x;
		// ten series terms, divisor (2k)(2k+1), alternating sign
		term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
		term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
		term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
		term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
		term = mul_q62(term, x2) / 64'd110; sum = sum - term;
		term = mul_q62(term, x2) / 64'd156; sum = sum + term;
		term = mul_q62(term, x2) / 64'd210; sum = sum - term;
		term = mul_q62(term, x2) / 64'd272; sum = sum + term;
		term = mul_q62(term, x2) / 64'd342; sum = sum - term;
		term = mul_q62(term, x2) / 64'd420; sum = sum + term;
		if (sum > ONE_Q62) sum = ONE_Q62;
		t = (sum >> 20) * 64'(AMP) + (64'd1 << 41);
		if (n == 64'd0) t = 64'd0;
		return MAG_BITS'(t >> 42);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t r;
		for (int j = 0; j <= QTR_SIZE; j++) begin
			r[j] = sine_mag(j);
		end
		return r;
	endfunction

	// fold a table index onto the quarter wave (sign comes from the top bit)
	function automatic qaddr_t quarter_addr(input addr_t idx);
		logic [ADDR_BITS-2:0] h;
		addr_t                m;
		h = idx[ADDR_BITS-2:0];
		m = ADDR_BITS'(TABLE_SIZE / 2) - {1'b0, h};
		if ({1'b0, h} > ADDR_BITS'(QTR_SIZE)) return QADDR_BITS'(m);
		else return QADDR_BITS'(h);
	endfunction

endpackage

@@ rtl/wto_phase.sv @@
// wto_phase: phase accumulator and table position of the current request.
// Depends on wto_pkg.
module wto_phase (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic                              restart,
	input  logic [wto_pkg::STEP_BITS-1:0]     step,
	output wto_pkg::phase_pos_t               pos
);
	import wto_pkg::*;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] phase_cur;

	// restart zeroes the phase ahead of this sample
	assign phase_cur = restart ? '0 : phase_q;

	assign pos.idx0 = phase_cur[PHASE_BITS-1 -: ADDR_BITS];
	assign pos.idx1 = phase_cur[PHASE_BITS-1 -: ADDR_BITS] + addr_t'(1);
	assign pos.frac = phase_cur[PHASE_FRAC_BITS-1 -: FRAC_BITS];

	// power-of-two table: wrap is the natural carry-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_cur + PHASE_BITS'(step);
		end
	end
endmodule

@@ rtl/wto_sine_rom.sv @@
// wto_sine_rom: quarter-wave sine magnitude ROM with two registered read ports.
// Depends on wto_pkg (contents built at elaboration).
module wto_sine_rom (
	input  logic                  clk,
	input  logic                  en,
	input  wto_pkg::qaddr_t       addr_a,
	input  wto_pkg::qaddr_t       addr_b,
	output wto_pkg::mag_t         mag_a,
	output wto_pkg::mag_t         mag_b
);
	import wto_pkg::*;

	localparam sine_rom_t SineRom = build_sine_rom();

	always_ff @(posedge clk) begin
		if (en) begin
			mag_a <= SineRom[addr_a];
			mag_b <= SineRom[addr_b];
		end
	end
endmodule

@@ rtl/wto_interp.sv @@
// wto_interp: table entry selection per shape and linear interpolation.
// Depends on wto_pkg.
module wto_interp (
	input  logic [wto_pkg::SHAPE_BITS-1:0] shape,
	input  wto_pkg::phase_pos_t            pos,
	input  wto_pkg::mag_t                  mag0,
	input  wto_pkg::mag_t                  mag1,
	output wto_pkg::sample_t               value
);
	import wto_pkg::*;

	function automatic sample_t entry(input logic [SHAPE_BITS-1:0] shp, input addr_t idx,
			input mag_t mag);
		sample_t sv;
		sv = '0;
		case (shp)
			SHAPE_SINE: begin
				sv = idx[ADDR_BITS-1] ? -sample_t'({1'b0, mag}) : sample_t'({1'b0, mag});
			end
			SHAPE_SAW: begin
				sv = sample_t'({~idx[ADDR_BITS-1], idx[ADDR_BITS-2:0],
					{(SAMPLE_BITS - ADDR_BITS){1'b0}}});
			end
			SHAPE_SQUARE: begin
				sv = idx[ADDR_BITS-1] ? -sample_t'(AMP) : sample_t'(AMP);
			end
			default: sv = '0;  // reserved shape: silence
		endcase
		return sv;
	endfunction

	sample_t                             v0, v1;
	logic signed [SAMPLE_BITS:0]         diff;
	logic signed [2*SAMPLE_BITS+1:0]     prod;
	logic signed [2*SAMPLE_BITS+2:0]     rnd;
	logic signed [SAMPLE_BITS+2:0]       delta;
	logic signed [SAMPLE_BITS+2:0]       sum;

	assign v0    = entry(shape, pos.idx0, mag0);
	assign v1    = entry(shape, pos.idx1, mag1);
	assign diff  = (SAMPLE_BITS+1)'(v1) - (SAMPLE_BITS+1)'(v0);
	assign prod  = (2*SAMPLE_BITS+2)'(diff) * (2*SAMPLE_BITS+2)'(signed'({1'b0, pos.frac}));
	// round half up, floor division by 2^16
	assign rnd   = (2*SAMPLE_BITS+3)'(prod) + (2*SAMPLE_BITS+3)'(32768);
	assign delta = (SAMPLE_BITS+3)'(rnd >>> FRAC_BITS);
	assign sum   = (SAMPLE_BITS+3)'(v0) + delta;
	// result lies between v0 and v1
	assign value = sample_t'(sum);
endmodule

@@ rtl/wavetable_oscillator.sv @@
// wavetable_oscillator: phase-accumulator oscillator with linear interpolation.
// Top level; depends on wto_pkg, wto_phase, wto_sine_rom, wto_interp.
//
// Usage:
//  - Request channel (in_valid / in_stall, fields restart, block_last): each
//    request asks for one sample. restart zeroes the phase before this sample.
//  - Result channel (out_valid / out_stall, fields sample, block_end): one
//    signed Q1.15 sample per request, in request order; block_end copies
//    block_last.
//  - Config port: cfg_we writes cfg_data into register cfg_index
//    (0 wave_shape, 1 phase_step as 11.21 table units per sample). Write only
//    while no request is in flight.
//  - Pipeline: an accepted request is registered in the ROM stage, then in the
//    output register, where the receiver takes it unless it stalls. Throughput
//    is one request per cycle while out_stall is low; the sine ROM read (two
//    registered ports) and the interpolation multiplier each take one stage.
//  - Stall: the output register holds its result while out_stall is high;
//    the ROM stage keeps one more request, after which in_stall rises.
//  - Reset (arst_n low): phase, wave_shape and phase_step clear to zero and
//    both pipeline stages empty; no ROM clearing is needed.
module wavetable_oscillator (
	input  logic                                clk,
	input  logic                                arst_n,
	// config
	input  logic                                cfg_we,
	input  logic [wto_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [wto_pkg::CFG_BITS-1:0]        cfg_data,
	// request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	input  logic                                block_last,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wto_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                block_end
);
	import wto_pkg::*;

	// config registers
	logic [SHAPE_BITS-1:0] shape_q;
	logic [STEP_BITS-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_SINE;
			step_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WAVE_SHAPE: shape_q <= cfg_data[SHAPE_BITS-1:0];
				CFG_PHASE_STEP: step_q  <= cfg_data[STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake: out register frees when empty or being taken
	logic in_acc, out_adv, s1_free;
	logic valid_s1, out_valid_q;

	assign out_adv  = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_adv;
	assign in_stall = !s1_free;
	assign in_acc   = in_valid && s1_free;

	// stage 0: phase and table position
	phase_pos_t pos;

	wto_phase u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (in_acc),
		.restart (restart),
		.step    (step_q),
		.pos     (pos)
	);

	// stage 1: ROM read, position carried alongside
	mag_t                  mag0_s1, mag1_s1;
	phase_pos_t            pos_s1;
	logic [SHAPE_BITS-1:0] shape_s1;
	logic                  last_s1;

	wto_sine_rom u_rom (
		.clk    (clk),
		.en     (in_acc),
		.addr_a (quarter_addr(pos.idx0)),
		.addr_b (quarter_addr(pos.idx1)),
		.mag_a  (mag0_s1),
		.mag_b  (mag1_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_s1   <= pos;
			shape_s1 <= shape_q;
			last_s1  <= block_last;
		end
	end

	// stage 2: interpolate into the output register
	sample_t value;
	sample_t sample_q;
	logic    block_end_q;

	wto_interp u_interp (
		.shape (shape_s1),
		.pos   (pos_s1),
		.mag0  (mag0_s1),
		.mag1  (mag1_s1),
		.value (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			sample_q    <= value;
			block_end_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign block_end = block_end_q;
endmodule

@@ rtl/wto_checker.sv @@
// wto_checker: port-level checks of the wavetable oscillator, bound to the top.
// Depends on wto_pkg and wavetable_oscillator.
module wto_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input wto_pkg::sample_t           sample,
	input logic                       block_end
);
	import wto_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(block_end))
		else $error("result changed while stalled");

	// a result only leaves once taken
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("result dropped without being taken");

	// requests are held back only when the output is blocked
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled while output is free");

	// an accepted request passes the ROM stage into the output register once that register is free
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 (!out_valid || !out_stall) |=> out_valid)
		else $error("accepted request produced no result");
endmodule

bind wavetable_oscillator wto_checker u_wto_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.sample    (sample),
	.block_end (block_end)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for wavetable_oscillator (sine/saw/square DDS).
// Holds its own sample predictor and scoreboard; depends on wto_pkg and the RTL.

module tb_top;

	import wto_pkg::SHAPE_SINE;
	import wto_pkg::SHAPE_SAW;
	import wto_pkg::SHAPE_SQUARE;
	import wto_pkg::CFG_WAVE_SHAPE;
	import wto_pkg::CFG_PHASE_STEP;

	localparam logic [1:0] SHAPE_RESERVED = 2'd3;  // decodes to silence
	localparam int         ENTRIES        = 2048;
	localparam int         INDEX_SHIFT    = 21;    // fractional phase bits
	localparam int         WEIGHT_SHIFT   = 5;     // 21 - 16 weight bits
	localparam int         PEAK           = 32767;
	localparam int         HOLD_CYCLES    = 80;    // long receiver hold-off
	localparam int         IDLE_LIMIT     = 3000;  // watchdog, cycles w/o progress
	localparam int         RAND_PHASES    = 10;
	localparam int         PHASE_ITEMS    = 63;

	// ------------------------------------------------------------------
	// Predictor + scoreboard: keeps its own phase accumulator and register
	// copies, computes the interpolated sample for every accepted request
	// and checks results in order.
	// ------------------------------------------------------------------
	class osc_tracker;
		typedef struct {
			logic signed [15:0] sample;
			logic               block_end;
		} osc_result_t;

		osc_result_t expected_q[$];
		int          sine_lut[ENTRIES];
		logic [1:0]  shape;
		logic [31:0] step_word;
		logic [31:0] phase;
		int          failures;

		function new();
			for (int i = 0; i < ENTRIES; i++) sine_lut[i] = sine_point(i);
			shape     = SHAPE_SINE;
			step_word = '0;
			phase     = '0;
			failures  = 0;
		endfunction

		// Q62 fixed-point product
		static function longint unsigned q62_product(longint unsigned a, longint unsigned b);
			logic [127:0] wide;
			wide = 128'(a) * 128'(b);
			return 64'(wide >> 62);
		endfunction

		// round(PEAK*sin(2*pi*i/ENTRIES)) via folded Taylor series in Q62
		static function int sine_point(int unsigned i);
			longint unsigned n, q, whole, rem, hi, r2, f, x, x2, term, acc, mag;
			bit              neg;
			n   = 64'(ENTRIES);
			q   = 4 * longint'(i);
			neg = 1'b0;
			if (q >= 2 * n) begin
				neg = 1'b1;
				q   = q - 2 * n;
			end
			if (q > n) q = 2 * n - q;
			whole = q / n;
			rem   = q % n;
			hi    = (rem << 40) / n;
			r2    = (rem << 40) % n;
			f     = (whole << 62) + (hi << 22) + ((r2 << 22) / n);
			x     = q62_product(f, 64'h6487_ED51_10B4_611A);  // pi/2 in Q62
			x2    = q62_product(x, x);
			term  = x;
			acc   = x;
			for (int k = 1; k <= 10; k++) begin
				term = q62_product(term, x2) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) acc = acc - term;
				else acc = acc + term;
			end
			if (acc > (64'd1 << 62)) acc = 64'd1 << 62;
			mag = ((acc >> 20) * PEAK + (64'd1 << 41)) >> 42;
			return neg ? -int'(mag) : int'(mag);
		endfunction

		function int wave_point(logic [10:0] idx);
			case (shape)
				SHAPE_SINE:   return sine_lut[idx];
				SHAPE_SAW:    return int'(idx) * (65536 / ENTRIES) - 32768;
				SHAPE_SQUARE: return (int'(idx) < ENTRIES / 2) ? PEAK : -PEAK;
				default:      return 0;
			endcase
		endfunction

		// accepted request: compute the sample, then advance the phase
		function void take_request(logic rs, logic bl);
			osc_result_t  r;
			logic [10:0]  idx0, idx1;
			logic [15:0]  weight;
			int           v0, v1;
			longint       w, prod;
			if (rs) phase = '0;
			idx0   = 11'(phase >> INDEX_SHIFT);
			idx1   = idx0 + 11'd1;          // wraps at the table end
			weight = 16'(phase >> WEIGHT_SHIFT);
			v0     = wave_point(idx0);
			v1     = wave_point(idx1);
			w      = longint'(weight);
			prod   = longint'(v1 - v0) * w + 32768;
			r.sample    = 16'(v0 + int'(prod >>> 16));
			r.block_end = bl;
			expected_q.push_back(r);
			phase = phase + step_word;      // modulus is exactly 2^32
		endfunction

		function void check_sample(logic signed [15:0] got_sample, logic got_end);
			osc_result_t r;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: unexpected sample %0d block_end %0b",
						$time, got_sample, got_end);
				return;
			end
			r = expected_q.pop_front();
			if (got_sample !== r.sample || got_end !== r.block_end) begin
				failures++;
				if (failures <= 10)
					$display("%0t: sample exp %0d got %0d, block_end exp %0b got %0b",
						$time, r.sample, got_sample, r.block_end, got_end);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Signals and DUT
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [wto_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [wto_pkg::CFG_BITS-1:0]     cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        restart;
	logic        block_last;
	logic        out_valid;
	logic        out_stall;
	logic signed [wto_pkg::SAMPLE_BITS-1:0] sample;
	logic        block_end;

	osc_tracker  sb;
	bit          quiet;          // last stretch: no idling on either side
	bit          long_hold_req;  // asks the receiver for one long hold-off
	int          tx_gap_pct;
	int          rx_gap_pct;

	wavetable_oscillator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.restart    (restart),
		.block_last (block_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample     (sample),
		.block_end  (block_end)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Monitor: both handshakes are sampled with their pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.take_request(restart, block_last);
			if (out_valid && !out_stall) sb.check_sample(sample, block_end);
		end
	end

	// Watchdog: ends the run when neither channel moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("wavetable_oscillator verification failed");
		$finish;
	end

	// Receiver: random stall bursts, plus one long hold-off on request so the
	// pipeline fills and pushes back on the request side.
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(99) < rx_gap_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request-side tasks
	// ------------------------------------------------------------------

	// offer one request and hold it until accepted
	task automatic push_request(input logic rs, input logic bl);
		in_valid   <= 1'b1;
		restart    <= rs;
		block_last <= bl;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid for a random burst; fields get junk meanwhile
	task automatic idle_burst();
		in_valid   <= 1'b0;
		restart    <= 1'($urandom);
		block_last <= 1'($urandom);
		repeat ($urandom_range(1, 16)) @(posedge clk);
	endtask

	// stop sending and wait until every sample is back, then a short margin
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers; only called while the block is drained
	task automatic program_osc(input logic [31:0] shape_word, input logic [31:0] step_val);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WAVE_SHAPE;
		cfg_data  <= shape_word;
		@(posedge clk);
		sb.shape  = shape_word[1:0];
		cfg_index <= CFG_PHASE_STEP;
		cfg_data  <= step_val;
		@(posedge clk);
		sb.step_word = step_val;
		cfg_we    <= 1'b0;
	endtask

	// directed burst: n requests, optional restart on the first one
	task automatic burst(input int n, input bit restart_first);
		for (int i = 0; i < n; i++) push_request(restart_first && i == 0, 1'(i));
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [1:0]  shape_v;
		logic [31:0] step_v;
		sb = new();
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		tx_gap_pct    = 0;
		rx_gap_pct    = 0;
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_WAVE_SHAPE;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		restart    <= 1'b0;
		block_last <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Reset defaults first: sine, zero step, phase 0.
		burst(2, 1'b0);
		drain();
		// one whole table entry per sample
		program_osc({30'd0, SHAPE_SAW}, 32'd1 << INDEX_SHIFT);
		burst(3, 1'b1);
		drain();
		// largest step: wraps to one LSB short of a full table
		program_osc({30'd0, SHAPE_SQUARE}, 32'hFFFF_FFFF);
		burst(3, 1'b1);
		drain();
		// all-ones shape word: reserved code, upper bits ignored, silence
		program_osc(32'hFFFF_FFFF, 32'h0010_0001);
		burst(2, 1'b0);
		drain();
		program_osc({30'd0, SHAPE_SINE}, 32'h0010_0001);
		burst(4, 1'b1);
		drain();
		// lands on the last entry with maximum weight: saw top-to-bottom edge
		program_osc({30'd0, SHAPE_SAW}, {11'd2047, 21'h1F_FFE0});
		burst(3, 1'b1);
		drain();
		program_osc({30'd0, SHAPE_SQUARE}, 32'h8000_0000);
		burst(3, 1'b1);
		drain();
		// smallest weight step
		program_osc({30'd0, SHAPE_SINE}, 32'd1 << WEIGHT_SHIFT);
		burst(2, 1'b1);
		drain();

		// Random part: each phase picks a setting, then streams requests.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			shape_v = ($urandom_range(9) < 9) ? 2'($urandom_range(2)) : SHAPE_RESERVED;
			case ($urandom_range(5))
				0: step_v = $urandom;
				1: step_v = $urandom_range(32'h00FF_FFFF);
				2: step_v = $urandom_range(32'h0FFF_FFFF);
				3: step_v = 32'hFFFF_FFFF - $urandom_range(255);
				4: step_v = {11'($urandom_range(2047)), 21'd0};
				default: step_v = $urandom & 32'h001F_FFFF;
			endcase
			if (ph == RAND_PHASES - 1) step_v = '0;  // zero step at the end too
			program_osc(($urandom & ~32'h3) | {30'd0, shape_v}, step_v);

			tx_gap_pct = (ph % 3 == 0) ? 0 : $urandom_range(5, 30);
			rx_gap_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 30);
			quiet      = (ph == RAND_PHASES - 1);
			if (ph == 2) begin
				// sender keeps streaming while the receiver holds off
				tx_gap_pct    = 0;
				long_hold_req = 1'b1;
			end

			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (!quiet && $urandom_range(99) < tx_gap_pct) idle_burst();
				push_request($urandom_range(15) == 0, $urandom_range(3) == 0);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("wavetable_oscillator verification clean");
		else
			$display("wavetable_oscillator verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/wto_pkg.sv
rtl/wto_phase.sv
rtl/wto_sine_rom.sv
rtl/wto_interp.sv
rtl/wavetable_oscillator.sv
rtl/wto_checker.sv
bench/tb_top.sv
